// ----- rtl/phacc_pkg.sv -----
// Shared types, register map and reset values of the phase accumulator.
`timescale 1ns / 1ps

package phacc_pkg;

    localparam int PHASE_BITS_DEF = 32;
    localparam int APB_ADDR_W     = 3;

    localparam logic REG_HOLD_MODE = 1'b0;
    localparam logic REG_INV_RATE  = 1'b1;

    localparam logic        HOLD_MODE_RST = 1'b1;
    localparam logic [31:0] INV_RATE_RST  = 32'd89478;

    localparam logic CMD_SAMPLE    = 1'b0;
    localparam logic CMD_SET_PHASE = 1'b1;

    typedef struct packed {
        logic        hold_mode;
        logic [31:0] inv_rate;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic cmd;
    } t_step;

endpackage

// ----- rtl/phase_accumulator_with_freq_hold.sv -----
// Top level of the phase accumulator with frequency hold.
//
//   Channel  Direction  Payload
//   s        in         tuser: command; tdata: frequency [31:0], new_phase [63:32]
//   m        out        tdata: phase_out [31:0], freq_out [63:32]
//   apb      in/out     hold_mode at 0x0, inv_rate at 0x4
//
// One item is taken per cycle unless the output stalls; a sample's result is registered.
// The loop that sets the rate is the 33 by 32 multiply and 64-bit add feeding the phase.
// A set-phase command leaves the input register without waiting and gives no result.
// Reset clears phase and held frequency, sets hold mode, and sets inv_rate to 89478.
// A stalled result waits in the output register while one more item waits at the input.
`timescale 1ns / 1ps

module phase_accumulator_with_freq_hold #(
    parameter int PHASE_BITS = phacc_pkg::PHASE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [63:0]                       i_s_tdata,  // frequency, new_phase
    input  logic                              i_s_tuser,  // command
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [63:0]                       o_m_tdata,  // phase_out, freq_out
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [phacc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    phacc_pkg::t_cfg  w_cfg;
    phacc_pkg::t_step w_step;

    logic               r_in_valid;
    logic               r_in_cmd;
    logic signed [31:0] r_in_freq;
    logic [31:0]        r_in_phase;
    logic               r_out_valid;
    logic [63:0]        r_out_data;

    logic               w_out_free;
    logic               w_in_move;
    logic               w_in_fire;
    logic [31:0]        w_phase_out;
    logic signed [31:0] w_freq_out;

    phacc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_in_move  = r_in_valid &&
                        ((r_in_cmd == phacc_pkg::CMD_SET_PHASE) || w_out_free);
    assign o_s_tready = !r_in_valid || w_in_move;
    assign w_in_fire  = i_s_tvalid && o_s_tready;

    assign w_step.valid = w_in_move;
    assign w_step.cmd   = r_in_cmd;

    phacc_core #(
        .PHASE_BITS (PHASE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_step      (w_step),
        .i_frequency (r_in_freq),
        .i_new_phase (r_in_phase),
        .o_phase_out (w_phase_out),
        .o_freq_out  (w_freq_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_in_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_cmd   <= i_s_tuser;
            r_in_freq  <= i_s_tdata[31:0];
            r_in_phase <= i_s_tdata[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_move && (r_in_cmd == phacc_pkg::CMD_SAMPLE)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_move && (r_in_cmd == phacc_pkg::CMD_SAMPLE)) begin
            r_out_data <= {w_freq_out, w_phase_out};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_sample_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_move && (r_in_cmd == phacc_pkg::CMD_SAMPLE)) |=> o_m_tvalid)
        else $error("a processed sample gave no result");

endmodule

// ----- rtl/phacc_cfg.sv -----
// APB register file holding the hold mode and the phase step per hertz.
`timescale 1ns / 1ps

module phacc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [phacc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output phacc_pkg::t_cfg                    o_cfg
);

    logic        r_hold_mode;
    logic [31:0] r_inv_rate;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_mode <= phacc_pkg::HOLD_MODE_RST;
            r_inv_rate  <= phacc_pkg::INV_RATE_RST;
        end else if (w_wr) begin
            case (paddr[2])
                phacc_pkg::REG_HOLD_MODE: r_hold_mode <= pwdata[0];
                phacc_pkg::REG_INV_RATE:  r_inv_rate  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            case (paddr[2])
                phacc_pkg::REG_HOLD_MODE: prdata = {31'd0, r_hold_mode};
                phacc_pkg::REG_INV_RATE:  prdata = r_inv_rate;
                default:                  prdata = 32'd0;
            endcase
        end
    end

    assign o_cfg.hold_mode = r_hold_mode;
    assign o_cfg.inv_rate  = r_inv_rate;

endmodule

// ----- rtl/phacc_core.sv -----
// Phase register, frequency hold logic and the multiply-add phase step.
`timescale 1ns / 1ps

module phacc_core #(
    parameter int PHASE_BITS = phacc_pkg::PHASE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  phacc_pkg::t_cfg     i_cfg,
    input  phacc_pkg::t_step    i_step,
    input  logic signed [31:0]  i_frequency,
    input  logic [31:0]         i_new_phase,
    output logic [31:0]         o_phase_out,
    output logic signed [31:0]  o_freq_out
);

    localparam int UP_SHIFT = (PHASE_BITS >= 32) ? (PHASE_BITS - 32) : 0;
    localparam int DN_SHIFT = (PHASE_BITS < 32) ? (32 - PHASE_BITS) : 0;

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic signed [31:0]    r_held;
    logic signed [31:0]    n_held;
    logic                  r_wrapped;
    logic                  n_wrapped;

    logic signed [31:0]    w_held_sel;
    logic signed [31:0]    w_use;
    logic signed [63:0]    w_prod;
    logic signed [63:0]    w_inc;
    logic [63:0]           w_sum;
    logic                  w_wrap;
    logic [63:0]           w_ph64;
    logic [63:0]           w_np64;
    logic [PHASE_BITS-1:0] w_load_phase;

    always_comb begin
        w_held_sel = r_held;
        if (i_cfg.hold_mode &&
            (((i_frequency != 32'sd0) && (r_held == 32'sd0)) || r_wrapped)) begin
            w_held_sel = i_frequency;
        end
        w_use = i_cfg.hold_mode ? w_held_sel : i_frequency;
    end

    assign w_prod = 64'(w_use) * $signed({32'd0, i_cfg.inv_rate});
    assign w_inc  = w_prod >>> 16;
    assign w_sum  = {{(64-PHASE_BITS){1'b0}}, r_phase} + $unsigned(w_inc);
    assign w_wrap = |w_sum[63:PHASE_BITS];

    assign w_ph64 = {{(64-PHASE_BITS){1'b0}}, r_phase};
    assign w_np64 = {32'd0, i_new_phase};
    assign w_load_phase = (PHASE_BITS >= 32) ? PHASE_BITS'(w_np64 << UP_SHIFT)
                                             : PHASE_BITS'(w_np64 >> DN_SHIFT);

    assign o_phase_out = (PHASE_BITS >= 32) ? 32'(w_ph64 >> UP_SHIFT)
                                            : 32'(w_ph64 << DN_SHIFT);
    assign o_freq_out  = w_use;

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_wrapped = r_wrapped;
        if (i_step.valid) begin
            if (i_step.cmd == phacc_pkg::CMD_SET_PHASE) begin
                n_phase   = w_load_phase;
                n_wrapped = 1'b0;
            end else begin
                n_phase   = w_sum[PHASE_BITS-1:0];
                n_held    = w_held_sel;
                n_wrapped = w_wrap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_held    <= '0;
            r_wrapped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_wrapped <= n_wrapped;
        end
    end

    a_set_phase_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.valid && (i_step.cmd == phacc_pkg::CMD_SET_PHASE))
        |=> (r_phase == $past(w_load_phase)) && !r_wrapped)
        else $error("set phase did not load the phase or clear the wrap flag");

    a_idle_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step.valid |=> $stable(r_phase) && $stable(r_held) && $stable(r_wrapped))
        else $error("state changed without a step");

    a_follow_keeps_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.valid && !i_cfg.hold_mode) |=> $stable(r_held))
        else $error("held frequency changed outside hold mode");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the phase accumulator with frequency hold.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;

    typedef struct {
        logic [31:0] phase;
        logic [31:0] freq;
    } t_nco_result;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata  = '0;  // frequency [31:0], new_phase [63:32]
    logic        i_s_tuser  = 1'b0;  // command
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;  // phase_out [31:0], freq_out [63:32]
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [phacc_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        hold_on;
    logic [31:0] step_per_hz;
    logic [31:0] phase_now;
    logic [31:0] freq_latched;
    logic        left_cycle;

    t_nco_result pending_results[$];

    int send_idle_pct = 22;
    int recv_idle_pct = 46;
    int n_errors      = 0;
    int n_samples     = 0;
    int n_set_phase   = 0;
    int n_reg_writes  = 0;
    int n_checked     = 0;
    int n_wraps       = 0;
    int cycle_count   = 0;

    phase_accumulator_with_freq_hold uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_nco_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("Unexpected transfer on the output, tdata %h", o_m_tdata);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_m_tdata[31:0] !== want.phase) begin
                    $error("phase_out: expected %h, actual %h", want.phase, o_m_tdata[31:0]);
                    n_errors++;
                end
                if (o_m_tdata[63:32] !== want.freq) begin
                    $error("freq_out: expected %h, actual %h", want.freq, o_m_tdata[63:32]);
                    n_errors++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic predict_item(input logic cmd, input logic [31:0] freq,
                                input logic [31:0] new_phase);
        logic [31:0]        use_freq;
        logic signed [63:0] freq_wide;
        logic signed [63:0] rate_wide;
        logic signed [63:0] product;
        logic signed [63:0] increment;
        logic [63:0]        total;
        if (cmd == phacc_pkg::CMD_SET_PHASE) begin
            phase_now  = new_phase;
            left_cycle = 1'b0;
            n_set_phase++;
        end else begin
            if (hold_on) begin
                if ((freq != 0 && freq_latched == 0) || left_cycle)
                    freq_latched = freq;
                use_freq = freq_latched;
            end else begin
                use_freq = freq;
            end
            pending_results.push_back('{phase: phase_now, freq: use_freq});
            freq_wide  = {{32{use_freq[31]}}, use_freq};
            rate_wide  = {32'd0, step_per_hz};
            product    = freq_wide * rate_wide;
            increment  = product >>> 16;
            total      = {32'd0, phase_now} + increment;
            left_cycle = (total[63:32] != 0);
            phase_now  = total[31:0];
            n_samples++;
            if (left_cycle)
                n_wraps++;
        end
    endtask

    task automatic send_item(input logic cmd, input logic [31:0] freq,
                             input logic [31:0] new_phase);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {new_phase, freq};
        do @(posedge i_clk); while (!o_s_tready);
        predict_item(cmd, freq, new_phase);
    endtask

    task automatic send_sample(input logic [31:0] freq);
        send_item(phacc_pkg::CMD_SAMPLE, freq, $urandom());
    endtask

    task automatic send_set_phase(input logic [31:0] new_phase);
        send_item(phacc_pkg::CMD_SET_PHASE, $urandom(), new_phase);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == phacc_pkg::REG_HOLD_MODE)
            hold_on = value[0];
        else
            step_per_hz = value;
        n_reg_writes++;
    endtask

    task automatic configure(input logic hold, input logic [31:0] rate);
        wait_idle();
        reg_write(phacc_pkg::REG_HOLD_MODE, {31'd0, hold});
        reg_write(phacc_pkg::REG_INV_RATE, rate);
    endtask

    task automatic test_hold_latching();
        send_sample(32'd0);
        send_sample(32'd1000 << 16);
        send_sample(32'd5 << 16);
        send_set_phase(32'hFFFF_FFFF);
        send_sample(32'd7 << 16);
        send_sample(-(32'sd300 <<< 16));
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_set_phase(32'h0000_0000);
        send_sample(32'd0);
    endtask

    task automatic test_follow_and_rate_extremes();
        configure(1'b0, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
        send_set_phase(32'h8000_0000);
        send_sample(32'h0001_0000);
        configure(1'b1, 32'd0);
        send_sample(32'd12345);
        send_set_phase(32'hA5A5_A5A5);
        send_sample(32'h5A5A_5A5A);
        send_sample(32'h8000_0000);
    endtask

    task automatic random_item();
        int unsigned mag;
        logic [31:0] freq;
        if ($urandom_range(99) < 12) begin
            if ($urandom_range(3) == 0)
                send_set_phase({16'hFFFF, 16'($urandom())});
            else
                send_set_phase($urandom());
        end else begin
            case ($urandom_range(9))
                0: freq = 32'd0;
                1: freq = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                2, 3: freq = $urandom();
                default: begin
                    mag  = $urandom_range(20000 * 65536);
                    freq = $urandom_range(1) ? mag : -mag;
                end
            endcase
            send_sample(freq);
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_phases);
        logic [31:0] rate;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n_phases) begin
            case ($urandom_range(4))
                0: rate = 32'd0;
                1: rate = 32'hFFFF_FFFF;
                2: rate = phacc_pkg::INV_RATE_RST;
                3: rate = $urandom_range(1 << 20);
                default: rate = $urandom();
            endcase
            configure(1'($urandom_range(1)), rate);
            repeat (100) random_item();
        end
    endtask

    initial begin
        hold_on      = phacc_pkg::HOLD_MODE_RST;
        step_per_hz  = phacc_pkg::INV_RATE_RST;
        phase_now    = '0;
        freq_latched = '0;
        left_cycle   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_hold_latching();
        test_follow_and_rate_extremes();
        test_random_traffic(22, 46, 3);
        test_random_traffic(46, 22, 2);
        test_random_traffic(0, 0, 2);
        wait_idle();
        $display("Covered %0d samples and %0d set-phase commands across %0d register writes.",
                 n_samples, n_set_phase, n_reg_writes);
        $display("Checked %0d results; %0d samples moved the phase across a cycle boundary.",
                 n_checked, n_wraps);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
